[hdl/sata_dma_command_builder_macros.svh]
// Assertion macros used by the command builder checker.
`ifndef SATA_DMA_COMMAND_BUILDER_MACROS_SVH
`define SATA_DMA_COMMAND_BUILDER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SDCB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sata_dma_command_builder: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define SDCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sata_dma_command_builder: next-cycle check failed");

`endif

[hdl/sdcb_pkg.sv]
// Types and constants of the SATA DMA command builder.
package sdcb_pkg;

  localparam int DEF_MAX_REGION_ENTRIES = 32;
  localparam int DEF_SECTORS_PER_ENTRY  = 16;
  localparam int DEF_SLOT_COUNT         = 32;
  localparam int QUEUE_DEPTH            = 2;
  localparam int SECTOR_SHIFT           = 9;

  localparam logic [7:0] CMD_READ_EXT  = 8'h25;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h35;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_ENTRY   = 2'd1;
  localparam logic [1:0] KIND_NO_SLOT = 2'd2;
  localparam logic [1:0] KIND_BAD_CNT = 2'd3;

  typedef struct packed {
    logic        is_write;
    logic [47:0] start_sector;
    logic [15:0] sector_count;
    logic [63:0] buffer_address;
    logic [31:0] busy_slots;
  } req_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [4:0]  slot_index;
    logic        write_flag;
    logic [7:0]  command_code;
    logic [47:0] fis_lba;
    logic [15:0] fis_count;
    logic [5:0]  entry_total;
    logic [63:0] region_address;
    logic [12:0] region_bytes_minus_one;
    logic        last_item;
  } res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic        wr;
    logic [47:0] lba;
    logic [15:0] count;
    logic [5:0]  entries;
    logic [63:0] addr;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

[hdl/sdcb_front.sv]
// Request classifier: count check, lowest free slot, region entry count.
module sdcb_front #(
  parameter int MAX_REGION_ENTRIES = sdcb_pkg::DEF_MAX_REGION_ENTRIES,
  parameter int SECTORS_PER_ENTRY  = sdcb_pkg::DEF_SECTORS_PER_ENTRY,
  parameter int SLOT_COUNT         = sdcb_pkg::DEF_SLOT_COUNT
) (
  input  sdcb_pkg::req_t req,
  output sdcb_pkg::job_t job
);
  import sdcb_pkg::*;

  localparam logic [15:0] CAPACITY  = 16'(MAX_REGION_ENTRIES * SECTORS_PER_ENTRY);
  localparam logic [31:0] SLOT_MASK = 32'((64'd1 << SLOT_COUNT) - 64'd1);
  localparam int          RECIP_SHIFT = 24;
  localparam logic [24:0] RECIP =
    25'(((1 << RECIP_SHIFT) + SECTORS_PER_ENTRY - 1) / SECTORS_PER_ENTRY);

  logic [31:0] busy_m;
  logic [31:0] free_onehot;
  logic [4:0]  slot;
  logic        found;
  logic        bad;
  logic [15:0] count_m1;
  logic [37:0] entries_prod;

  always_comb begin
    busy_m      = req.busy_slots | ~SLOT_MASK;
    free_onehot = ~busy_m & (busy_m + 32'd1);
    found       = (busy_m != '1);
    slot        = '0;
    for (int i = 0; i < 32; i++) begin
      if (free_onehot[i]) slot = slot | 5'(i);
    end
    bad      = (req.sector_count == 16'd0) || (req.sector_count > CAPACITY);
    count_m1 = req.sector_count - 16'd1;
    // reciprocal multiply, exact for every count within capacity
    entries_prod = 38'(count_m1[12:0]) * 38'(RECIP);

    job         = '0;
    job.slot    = slot;
    job.wr      = req.is_write;
    job.lba     = req.start_sector;
    job.count   = req.sector_count;
    job.entries = entries_prod[29:24] + 6'd1;
    job.addr    = req.buffer_address;
    if (bad) begin
      job.kind = KIND_BAD_CNT;
    end else if (!found) begin
      job.kind = KIND_NO_SLOT;
    end else begin
      job.kind = KIND_HEADER;
    end
  end

endmodule

[hdl/sdcb_queue.sv]
// Short job queue between classifier and emitter.
module sdcb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sdcb_pkg::job_t         push_data,
  input  logic                   pop,
  output sdcb_pkg::job_t         pop_data,
  output sdcb_pkg::queue_status_t status
);
  import sdcb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == (PW + 1)'(QUEUE_DEPTH));
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW + 1)'(1);
      end
    end
  end

endmodule

[hdl/sdcb_back.sv]
// Result emitter: header item then one region entry per cycle, or a single error item.
module sdcb_back #(
  parameter int SECTORS_PER_ENTRY = sdcb_pkg::DEF_SECTORS_PER_ENTRY
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  sdcb_pkg::job_t job,
  output logic           pop,
  output logic           strobe,
  output sdcb_pkg::res_t result
);
  import sdcb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ENTRY
  } state_t;

  localparam logic [15:0] SPE = 16'(SECTORS_PER_ENTRY);

  state_t      state;
  job_t        cur;
  logic [5:0]  left;
  logic [15:0] remaining;
  logic [63:0] addr;

  logic        last_entry;
  logic [15:0] secs;
  logic [24:0] bytes;
  logic [24:0] bytes_m1;
  logic        strobe_next;
  res_t        result_next;

  assign pop = (state == ST_IDLE) && !empty;

  always_comb begin
    last_entry  = (left == 6'd1);
    secs        = last_entry ? remaining : SPE;
    bytes       = {secs, 9'd0};
    bytes_m1    = bytes - 25'd1;
    strobe_next = 1'b0;
    result_next = '0;
    case (state)
      ST_HEAD: begin
        strobe_next           = 1'b1;
        result_next.item_kind = cur.kind;
        if (cur.kind != KIND_HEADER) begin
          result_next.last_item = 1'b1;
        end else begin
          result_next.slot_index   = cur.slot;
          result_next.write_flag   = cur.wr;
          result_next.command_code = cur.wr ? CMD_WRITE_EXT : CMD_READ_EXT;
          result_next.fis_lba      = cur.lba;
          result_next.fis_count    = cur.count;
          result_next.entry_total  = cur.entries;
        end
      end
      ST_ENTRY: begin
        strobe_next                        = 1'b1;
        result_next.item_kind              = KIND_ENTRY;
        result_next.region_address         = addr;
        result_next.region_bytes_minus_one = bytes_m1[12:0];
        result_next.last_item              = last_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
      result <= result_next;
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            cur   <= job;
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (cur.kind != KIND_HEADER) begin
            state <= ST_IDLE;
          end else begin
            left      <= cur.entries;
            remaining <= cur.count;
            addr      <= cur.addr;
            state     <= ST_ENTRY;
          end
        end
        ST_ENTRY: begin
          addr      <= addr + 64'(bytes);
          remaining <= remaining - secs;
          left      <= left - 6'd1;
          if (last_entry) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/sata_dma_command_builder.sv]
// SATA DMA command builder top level: AHCI slot pick and PRDT entry generation.
// A request is taken when start is high and busy is low; busy rises only
// while the two-deep request queue is full. A good request yields a command
// header followed by one region entry per SECTORS_PER_ENTRY sectors, one
// result per cycle on consecutive cycles, with strobe marking each; a bad
// count or a full slot mask yields a single error item. The emitter loads a
// queued job from its idle state and takes no new job until it has finished
// the current one, whether a header and its entries or an error item. Results
// cannot be held off: the receiver must take every strobed result.
module sata_dma_command_builder #(
  parameter int MAX_REGION_ENTRIES = sdcb_pkg::DEF_MAX_REGION_ENTRIES,
  parameter int SECTORS_PER_ENTRY  = sdcb_pkg::DEF_SECTORS_PER_ENTRY,
  parameter int SLOT_COUNT         = sdcb_pkg::DEF_SLOT_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sdcb_pkg::req_t request,
  output logic           strobe,
  output sdcb_pkg::res_t result
);
  import sdcb_pkg::*;

  job_t          front_job;
  job_t          queue_job;
  queue_status_t queue_status;
  logic          pop;

  assign busy = queue_status.full;

  sdcb_front #(
    .MAX_REGION_ENTRIES(MAX_REGION_ENTRIES),
    .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY),
    .SLOT_COUNT        (SLOT_COUNT)
  ) u_front (
    .req(request),
    .job(front_job)
  );

  sdcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (start && !queue_status.full),
    .push_data(front_job),
    .pop      (pop),
    .pop_data (queue_job),
    .status   (queue_status)
  );

  sdcb_back #(
    .SECTORS_PER_ENTRY(SECTORS_PER_ENTRY)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (queue_status.empty),
    .job   (queue_job),
    .pop   (pop),
    .strobe(strobe),
    .result(result)
  );

endmodule

[hdl/sdcb_checker.sv]
// Port-level checks of the command builder and their binding.
`include "sata_dma_command_builder_macros.svh"

module sdcb_checker (
  input logic           clk,
  input logic           rst,
  input logic           strobe,
  input sdcb_pkg::res_t result
);
  import sdcb_pkg::*;

  `SDCB_ASSERT_NEXT(a_burst_contiguous, clk, rst, strobe && !result.last_item, strobe)
  `SDCB_ASSERT_NOW(a_error_is_last, clk, rst, strobe && (result.item_kind == KIND_NO_SLOT || result.item_kind == KIND_BAD_CNT), result.last_item)
  `SDCB_ASSERT_NEXT(a_header_then_entry, clk, rst, strobe && result.item_kind == KIND_HEADER, strobe && result.item_kind == KIND_ENTRY)
  `SDCB_ASSERT_NEXT(a_address_advance, clk, rst, strobe && result.item_kind == KIND_ENTRY && !result.last_item, result.region_address == $past(result.region_address) + 64'($past(result.region_bytes_minus_one)) + 64'd1)

endmodule

bind sata_dma_command_builder sdcb_checker u_sdcb_checker (
  .clk    (clk),
  .rst    (rst),
  .strobe (strobe),
  .result (result)
);
